>>> src/spp_pkg.sv
// Shared types, constants and tables of the block-code spread packetizer.
// Used by every module under src; depends on nothing else.
package spp_pkg;

	localparam int MSG_MAX   = 8;
	localparam int MSG_AW    = 3;
	localparam int MSG_LEN_W = 4;
	localparam int CHIP_LEN  = 64;
	localparam int CHIP_AW   = 6;
	localparam int CW_W      = 16;
	localparam int CW_AW     = 4;
	localparam int POS_W     = 16;
	localparam int SEQ_W     = 16;
	localparam logic [7:0] CHIPS_CAP = 8'd253;

	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_EMIT    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [1:0] CFG_MSG_LEN = 2'd0;
	localparam logic [1:0] CFG_CHIPS   = 2'd1;
	localparam logic [1:0] CFG_FILLER  = 2'd2;

	localparam logic [3:0] MSG_LEN_RST = 4'd5;
	localparam logic [7:0] CHIPS_RST   = 8'd192;
	localparam logic [7:0] FILLER_RST  = 8'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] msg_index;
		logic [7:0] msg_byte;
	} req_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_last;
		logic       message_done;
	} rsp_beat_t;

	typedef struct packed {
		logic             is_chip;
		logic [7:0]       hdr_byte;
		logic             filler;
		logic             last;
		logic [CW_AW-1:0] bit_sel;
		logic [7:0]       prn0;
		logic [7:0]       prn1;
		logic [7:0]       filler_byte;
	} s1_beat_t;

	localparam logic [CW_W-1:0] GEN_ROWS [8] = '{
		16'h809E, 16'h404E, 16'h20CD, 16'h1067,
		16'h0833, 16'h04F2, 16'h0278, 16'h01D7
	};

	localparam logic [7:0] PRN_ZERO [CHIP_LEN] = '{
		8'd253, 8'd62, 8'd119, 8'd213, 8'd37, 8'd239, 8'd44, 8'd105, 8'd42, 8'd233,
		8'd60, 8'd196, 8'd7, 8'd147, 8'd197, 8'd7, 8'd55, 8'd31, 8'd123, 8'd209,
		8'd186, 8'd7, 8'd144, 8'd55, 8'd223, 8'd90, 8'd237, 8'd200, 8'd140, 8'd105,
		8'd151, 8'd41, 8'd172, 8'd217, 8'd214, 8'd26, 8'd214, 8'd168, 8'd5, 8'd211,
		8'd106, 8'd203, 8'd214, 8'd82, 8'd63, 8'd231, 8'd130, 8'd134, 8'd110,
		8'd154, 8'd101, 8'd166, 8'd46, 8'd84, 8'd244, 8'd122, 8'd203, 8'd46, 8'd99,
		8'd191, 8'd84, 8'd196, 8'd212, 8'd84
	};

	localparam logic [7:0] PRN_ONE [CHIP_LEN] = '{
		8'd1, 8'd94, 8'd212, 8'd97, 8'd11, 8'd243, 8'd49, 8'd92, 8'd102, 8'd146,
		8'd91, 8'd42, 8'd224, 8'd163, 8'd0, 8'd225, 8'd187, 8'd159, 8'd49, 8'd207,
		8'd247, 8'd192, 8'd178, 8'd117, 8'd170, 8'd167, 8'd165, 8'd18, 8'd15, 8'd91,
		8'd2, 8'd61, 8'd78, 8'd96, 8'd142, 8'd23, 8'd52, 8'd133, 8'd97, 8'd69,
		8'd6, 8'd162, 8'd54, 8'd47, 8'd169, 8'd31, 8'd215, 8'd253, 8'd157, 8'd72,
		8'd25, 8'd24, 8'd175, 8'd54, 8'd147, 8'd0, 8'd16, 8'd133, 8'd40, 8'd29,
		8'd92, 8'd175, 8'd100, 8'd218
	};

	function automatic logic [CW_W-1:0] encode_byte(input logic [7:0] b);
		logic [CW_W-1:0] cw;
		cw = '0;
		for (int j = 0; j < 8; j++) begin
			if (b[7-j]) begin
				cw = cw ^ GEN_ROWS[j];
			end
		end
		return cw;
	endfunction

endpackage

>>> src/spp_msg_mem.sv
// Message store of the packetizer: one write port, one registered read port.
// Depends on spp_pkg.
module spp_msg_mem (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [spp_pkg::MSG_AW-1:0] wr_addr,
	input  logic [7:0]                wr_data,
	input  logic                      rd_en,
	input  logic [spp_pkg::MSG_AW-1:0] rd_addr,
	output logic [7:0]                rd_data
);
	import spp_pkg::*;

	logic [7:0] mem_q [MSG_MAX];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/spp_sequencer.sv
// Request stage: packet byte counter, sequence number, chip position and the
// first pipeline register. Depends on spp_pkg.
module spp_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  spp_pkg::req_beat_t          req_beat,
	input  logic [spp_pkg::MSG_LEN_W-1:0] message_length,
	input  logic [7:0]                  chips_per_packet,
	input  logic [7:0]                  filler_byte,
	input  logic                        s1_take,
	output logic                        s1_valid,
	output spp_pkg::s1_beat_t           s1_beat,
	output logic                        mem_wr_en,
	output logic                        mem_rd_en,
	output logic [spp_pkg::MSG_AW-1:0]  mem_rd_addr
);
	import spp_pkg::*;

	logic [SEQ_W-1:0]     seq_q;
	logic [7:0]           bip_q;
	logic [POS_W-1:0]     pos_q;
	logic                 s1_valid_q;
	s1_beat_t             s1_q;
	s1_beat_t             s1_next;
	logic                 fire;
	logic                 emit_fire;
	logic [7:0]           chips;
	logic [8:0]           last_idx;
	logic                 last;
	logic [MSG_LEN_W-1:0] msg_len;
	logic                 is_chip;
	logic                 past_msg;

	assign req_ready = !s1_valid_q || s1_take;
	assign fire      = req_valid && req_ready;
	assign emit_fire = fire && (req_beat.req_type == REQ_EMIT);
	assign mem_wr_en = fire && (req_beat.req_type == REQ_LOAD);
	assign mem_rd_en = emit_fire;
	assign mem_rd_addr = pos_q[CHIP_AW+CW_AW +: MSG_AW];

	assign chips    = (chips_per_packet > CHIPS_CAP) ? CHIPS_CAP : chips_per_packet;
	assign last_idx = {1'b0, chips} + 9'd1;
	assign last     = {1'b0, bip_q} >= last_idx;
	assign msg_len  = (message_length > MSG_LEN_W'(MSG_MAX)) ?
		MSG_LEN_W'(MSG_MAX) : message_length;
	assign is_chip  = bip_q >= 8'd2;
	assign past_msg = pos_q[POS_W-1:CHIP_AW] >=
		(POS_W-CHIP_AW)'({msg_len, {CW_AW{1'b0}}});

	always_comb begin
		s1_next.is_chip     = is_chip;
		s1_next.hdr_byte    = (bip_q == 8'd0) ? seq_q[15:8] : seq_q[7:0];
		s1_next.filler      = is_chip && past_msg;
		s1_next.last        = last;
		s1_next.bit_sel     = pos_q[CHIP_AW +: CW_AW];
		s1_next.prn0        = PRN_ZERO[pos_q[CHIP_AW-1:0]];
		s1_next.prn1        = PRN_ONE[pos_q[CHIP_AW-1:0]];
		s1_next.filler_byte = filler_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= '0;
			bip_q      <= '0;
			pos_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				unique case (req_beat.req_type)
					REQ_RESTART: begin
						seq_q <= '0;
						bip_q <= '0;
						pos_q <= '0;
					end
					REQ_EMIT: begin
						if (bip_q == 8'd1) begin
							seq_q <= seq_q + SEQ_W'(1);
						end
						if (is_chip && (pos_q != {POS_W{1'b1}})) begin
							pos_q <= pos_q + POS_W'(1);
						end
						bip_q <= last ? 8'd0 : bip_q + 8'd1;
					end
					default: begin
					end
				endcase
			end
			if (emit_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_take) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			s1_q <= s1_next;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_beat  = s1_q;

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_take |=> s1_valid_q && $stable(s1_q))
		else $error("s1 beat dropped or changed while stalled");
	a_pos_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && req_beat.req_type == REQ_RESTART) |=> pos_q >= $past(pos_q))
		else $error("chip position moved back without restart");
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire && bip_q == 8'd1 |=> seq_q == $past(seq_q) + SEQ_W'(1))
		else $error("sequence number not advanced after low header byte");
	a_bip_range: assert property (@(posedge clk) disable iff (!arst_n)
		bip_q <= 8'd254)
		else $error("packet byte counter out of range");
`endif

endmodule

>>> src/spp_spreader.sv
// Encode and spread stage: (16,8) codeword of the stored byte, chip select,
// and the output register. Depends on spp_pkg.
module spp_spreader (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s1_valid,
	input  spp_pkg::s1_beat_t  s1_beat,
	input  logic [7:0]         rd_data,
	output logic               s1_take,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output spp_pkg::rsp_beat_t rsp_beat
);
	import spp_pkg::*;

	logic [CW_W-1:0] cw;
	logic            cw_bit;
	rsp_beat_t       rsp_next;
	rsp_beat_t       rsp_q;
	logic            rsp_valid_q;

	assign s1_take = s1_valid && (!rsp_valid_q || rsp_ready);
	assign cw      = encode_byte(rd_data);
	assign cw_bit  = cw[~s1_beat.bit_sel];

	always_comb begin
		priority if (!s1_beat.is_chip) begin
			rsp_next.out_byte = s1_beat.hdr_byte;
		end else if (s1_beat.filler) begin
			rsp_next.out_byte = s1_beat.filler_byte;
		end else begin
			rsp_next.out_byte = cw_bit ? s1_beat.prn1 : s1_beat.prn0;
		end
		rsp_next.packet_last  = s1_beat.last;
		rsp_next.message_done = s1_beat.filler;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

`ifndef SYNTHESIS
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take |=> rsp_valid_q)
		else $error("taken beat did not reach the output register");
	a_done_is_chip: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && s1_beat.filler |-> s1_beat.is_chip)
		else $error("filler flag on a header beat");
`endif

endmodule

>>> src/block_code_spread_packetizer_unit.sv
// Top level of the block-code spread packetizer: configuration registers,
// message store, request stage and spread stage. Depends on spp_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req_beat) takes loads, emits and restarts.
//   A load writes one message byte; a restart clears sequence number, chip
//   position and packet byte counter. Neither returns a beat.
//   Each emit returns one rsp beat: two sequence header bytes (high first),
//   then chips_per_packet chip bytes (at most 253), packet_last on the final byte, and
//   filler with message_done once the chip position passes the message.
//   cfg channel writes message_length, chips_per_packet and filler_byte; it
//   is always ready. The user must write it only while no request is in flight;
//   the block itself does not enforce this.
// Timing: an accepted emit passes the store read and stage 1 register, then
//   encode/spread into the output register, where rsp_valid rises.
//   One request per cycle is sustained while rsp_ready stays high; the store's
//   single read port is read once per emit.
// Reset: counters clear, registers take their defaults (5, 192, 3), the
//   message store is undefined until loaded. When rsp stalls the two stages
//   fill and req_ready drops; nothing is lost.
module block_code_spread_packetizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  spp_pkg::req_beat_t req_beat,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output spp_pkg::rsp_beat_t rsp_beat,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import spp_pkg::*;

	logic [MSG_LEN_W-1:0] msg_len_q;
	logic [7:0]           chips_q;
	logic [7:0]           filler_q;
	logic                 cfg_fire;
	logic                 s1_take;
	logic                 s1_valid;
	s1_beat_t             s1_beat;
	logic                 mem_wr_en;
	logic                 mem_rd_en;
	logic [MSG_AW-1:0]    mem_rd_addr;
	logic [7:0]           rd_data;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= MSG_LEN_RST;
			chips_q   <= CHIPS_RST;
			filler_q  <= FILLER_RST;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				CFG_MSG_LEN: msg_len_q <= cfg_data[MSG_LEN_W-1:0];
				CFG_CHIPS:   chips_q   <= cfg_data;
				CFG_FILLER:  filler_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	spp_msg_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (req_beat.msg_index),
		.wr_data (req_beat.msg_byte),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	spp_sequencer u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.req_beat         (req_beat),
		.message_length   (msg_len_q),
		.chips_per_packet (chips_q),
		.filler_byte      (filler_q),
		.s1_take          (s1_take),
		.s1_valid         (s1_valid),
		.s1_beat          (s1_beat),
		.mem_wr_en        (mem_wr_en),
		.mem_rd_en        (mem_rd_en),
		.mem_rd_addr      (mem_rd_addr)
	);

	spp_spreader u_spread (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_beat   (s1_beat),
		.rd_data   (rd_data),
		.s1_take   (s1_take),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_beat  (rsp_beat)
	);

endmodule
